[rtl/cse_pkg.sv]
`timescale 1ns / 1ps
package cse_pkg;

	localparam int POS_W        = 6;
	localparam int CARRIER_DEF  = 39;
	localparam int SENTENCE_LEN = 39;
	localparam int MAX_RESULTS  = 12;
	localparam int CNT_W        = $clog2(MAX_RESULTS);
	localparam int NB_W         = 4;
	localparam int QUEUE_DEPTH  = 2;

	localparam logic [7:0] SPACE_CHAR = 8'h20;
	localparam logic [7:0] CASE_BIT   = 8'h20;

	localparam logic [1:0] MODE_5B = 2'd0;
	localparam logic [1:0] MODE_7B = 2'd1;
	localparam logic [1:0] MODE_8B = 2'd2;

	localparam logic [0:SENTENCE_LEN-1][7:0] CARRIER_ROM =
		"To be or not to be that is the question";

	// One classified beat handed from the front to the back.
	typedef struct packed {
		logic            bad;
		logic [NB_W-1:0] nbits;
		logic [7:0]      code;   // left aligned, next bit in code[7]
	} cse_item_t;

	function automatic logic [7:0] carrier_char(input logic [POS_W-1:0] pos);
		logic [7:0] c;
		c = SPACE_CHAR;
		if (pos < POS_W'(SENTENCE_LEN)) begin
			c = CARRIER_ROM[pos];
		end
		return c;
	endfunction

	function automatic logic is_letter(input logic [7:0] c);
		return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
	endfunction

endpackage

[rtl/case_steganography_encoder_top.sv]
`timescale 1ns / 1ps
// Channel  Dir  Handshake             Payload
// in       in   in_valid/in_ready     in_byte[7:0]
// out      out  out_valid/out_ready   out_char[7:0], illegal, last
// cfg      in   cfg_valid/cfg_ready   width_mode[1:0]
//
// Each byte is loaded into the back end, which then emits its output beats:
// 5 to 8 letters plus carrier spaces and wraps, 5 to 12 beats with the default
// sentence; the carrier sequencer emits one beat a cycle while out_ready allows it.
// An illegal byte yields one error beat and then halts the block until reset.
// Reset clears the carrier position, the halt flag and sets width_mode to 8 bits.
// out_ready low holds the output register; a two-entry queue keeps the front taking bytes.
module case_steganography_encoder_top import cse_pkg::*; #(
	parameter int CARRIER_LEN = CARRIER_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] in_byte,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] out_char,
	output logic       illegal,
	output logic       last,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [1:0] width_mode
);

	// front to queue
	logic      q_full;
	logic      q_push;
	cse_item_t push_item;

	// queue to back
	logic      q_pop;
	logic      q_empty;
	cse_item_t pop_item;

	// Classify each beat: pick the width, code the byte, flag illegal ones.
	// Drop every beat once an illegal byte has gone into the queue.
	cse_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.in_byte    (in_byte),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.width_mode (width_mode),
		.q_full     (q_full),
		.q_push     (q_push),
		.q_item     (push_item)
	);

	// Hold classified bytes while the back end is busy.
	cse_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_item (push_item),
		.full      (q_full),
		.pop       (q_pop),
		.empty     (q_empty),
		.pop_item  (pop_item)
	);

	// Walk the carrier sentence, one output beat per cycle unless out_ready stalls it, bits MSB first.
	cse_back #(
		.CARRIER_LEN (CARRIER_LEN)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_empty   (q_empty),
		.q_item    (pop_item),
		.q_pop     (q_pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_char  (out_char),
		.illegal   (illegal),
		.last      (last)
	);

endmodule

[rtl/cse_front.sv]
`timescale 1ns / 1ps
module cse_front import cse_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] in_byte,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [1:0] width_mode,
	input  logic       q_full,
	output logic       q_push,
	output cse_item_t  q_item
);

	logic [1:0] mode_q;
	logic       halted_q;
	logic       white;
	logic       accept;

	assign cfg_ready = 1'b1;
	// once halted, take every beat and drop it
	assign in_ready  = halted_q || !q_full;
	assign accept    = in_valid && in_ready;
	assign q_push    = accept && !halted_q;

	always_comb begin
		white = (in_byte == SPACE_CHAR) || (in_byte >= 8'h09 && in_byte <= 8'h0D);
		q_item.bad   = 1'b0;
		q_item.nbits = NB_W'(8);
		q_item.code  = white ? 8'h00 : in_byte;
		unique case (mode_q)
			MODE_5B: begin
				q_item.nbits = NB_W'(5);
				if (white) begin
					q_item.code = 8'h00;
				end else if (in_byte >= 8'h61 && in_byte <= 8'h7A) begin
					q_item.code = {5'(in_byte - 8'h60), 3'b000};
				end else begin
					q_item.code = 8'h00;
					q_item.bad  = 1'b1;
				end
			end
			MODE_7B: begin
				q_item.nbits = NB_W'(7);
				if (white) begin
					q_item.code = 8'h00;
				end else if (!in_byte[7] && in_byte != 8'h00) begin
					q_item.code = {in_byte[6:0], 1'b0};
				end else begin
					q_item.code = 8'h00;
					q_item.bad  = 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= MODE_8B;
			halted_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				mode_q <= width_mode;
			end
			if (q_push && q_item.bad) begin
				halted_q <= 1'b1;
			end
		end
	end

endmodule

[rtl/cse_fifo.sv]
`timescale 1ns / 1ps
module cse_fifo import cse_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  cse_item_t push_item,
	output logic      full,
	input  logic      pop,
	output logic      empty,
	output cse_item_t pop_item
);

	localparam int DEPTH = QUEUE_DEPTH;
	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	cse_item_t        mem_q [DEPTH];
	logic [PTR_W-1:0] wr_q;
	logic [PTR_W-1:0] rd_q;
	logic [CNT_W-1:0] cnt_q;

	assign full     = cnt_q == CNT_W'(DEPTH);
	assign empty    = cnt_q == '0;
	assign pop_item = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push && !full) begin
			mem_q[wr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push && !full) begin
				wr_q <= (wr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (pop && !empty) begin
				rd_q <= (rd_q == PTR_W'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			unique case ({push && !full, pop && !empty})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

[rtl/cse_back.sv]
`timescale 1ns / 1ps
module cse_back import cse_pkg::*; #(
	parameter int CARRIER_LEN = CARRIER_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       q_empty,
	input  cse_item_t  q_item,
	output logic       q_pop,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] out_char,
	output logic       illegal,
	output logic       last
);

	logic             busy_q;
	logic             bad_q;
	logic [7:0]       code_q;
	logic [NB_W-1:0]  bits_left_q;
	logic [CNT_W-1:0] cnt_q;
	logic [POS_W-1:0] pos_q;
	logic             out_valid_q;
	logic [7:0]       out_char_q;
	logic             out_illegal_q;
	logic             out_last_q;

	logic             step;
	logic             wrap;
	logic             take_bit;
	logic             done;
	logic [7:0]       cur_ch;
	logic [7:0]       step_ch;

	assign out_valid = out_valid_q;
	assign out_char  = out_char_q;
	assign illegal   = out_illegal_q;
	assign last      = out_last_q;

	assign step  = busy_q && (!out_valid_q || out_ready);
	assign q_pop = !busy_q && !q_empty;

	always_comb begin
		cur_ch   = carrier_char(pos_q);
		wrap     = pos_q >= POS_W'(CARRIER_LEN);
		take_bit = !wrap && is_letter(cur_ch);
		if (!take_bit) begin
			step_ch = SPACE_CHAR;
		end else if (code_q[7]) begin
			step_ch = cur_ch & ~CASE_BIT;
		end else begin
			step_ch = cur_ch | CASE_BIT;
		end
		done = (take_bit && bits_left_q == NB_W'(1)) || cnt_q == CNT_W'(MAX_RESULTS - 1);
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			bad_q       <= q_item.bad;
			code_q      <= q_item.code;
			bits_left_q <= q_item.nbits;
			cnt_q       <= '0;
		end else if (step && !bad_q) begin
			if (take_bit) begin
				code_q      <= {code_q[6:0], 1'b0};
				bits_left_q <= bits_left_q - 1'b1;
			end
			cnt_q <= cnt_q + 1'b1;
		end
		if (step) begin
			out_char_q    <= bad_q ? 8'h00 : step_ch;
			out_illegal_q <= bad_q;
			out_last_q    <= bad_q || done;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			pos_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (q_pop) begin
				busy_q <= 1'b1;
			end else if (step && (bad_q || done)) begin
				busy_q <= 1'b0;
			end
			if (step && !bad_q) begin
				pos_q <= wrap ? '0 : pos_q + 1'b1;
			end
			if (step) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q <= POS_W'(CARRIER_LEN))
		else $error("carrier position past wrap point");

	a_err_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_illegal_q |-> out_last_q && out_char_q == 8'h00)
		else $error("error beat not marked last");

	a_quiet_after_err: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_ready && out_illegal_q |=> !out_valid_q && !busy_q)
		else $error("activity after error beat");

	a_bits_pending: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q && !bad_q |-> bits_left_q != '0)
		else $error("busy with no bits left");

	a_pop_idle: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |=> busy_q && $stable(pos_q))
		else $error("load did not start an item");

endmodule
